### rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// shared constants, types and the byte-wide crc-32c fold
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int unsigned SECTOR_BYTES_DEFAULT = 512;

    localparam int unsigned CFG_W = 10;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CHECKED_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_EN   = 1'b1;

    localparam logic [CFG_W-1:0] CHECKED_BYTES_RESET = 10'd16;

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic go;
        logic fold;
        logic last;
    } scc_ctrl_t;

    function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/scc_sampler.sv
// ----------------------------------------------------------------------------
// scc_sampler
// sector offset tracking and fold decision
// ----------------------------------------------------------------------------
module scc_sampler
    import scc_pkg::*;
#(
    parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic             byte_valid,
    input  logic             block_end,
    input  logic [CFG_W-1:0] checked_bytes,
    output scc_ctrl_t        ctrl
);

    localparam int unsigned OFF_W = $clog2(SECTOR_BYTES);
    localparam int unsigned CMP_W = (OFF_W > CFG_W) ? OFF_W : CFG_W;
    localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(SECTOR_BYTES - 1);

    logic [OFF_W-1:0] offset_reg;
    logic [OFF_W-1:0] offset_next;
    logic [CMP_W-1:0] off_ext;
    logic [CMP_W-1:0] chk_ext;

    assign off_ext = CMP_W'(offset_reg);
    assign chk_ext = CMP_W'(checked_bytes);

    assign ctrl.go   = go;
    assign ctrl.fold = byte_valid && (off_ext < chk_ext);
    assign ctrl.last = block_end;

    always_comb
    begin
        offset_next = offset_reg;
        if (block_end)
        begin
            offset_next = '0;
        end
        else if (byte_valid)
        begin
            offset_next = (offset_reg == LAST_OFF) ? '0 : offset_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (go)
        begin
            offset_reg <= offset_next;
        end
    end

endmodule

### rtl/scc_crc_unit.sv
// ----------------------------------------------------------------------------
// scc_crc_unit
// running crc-32c register, byte fold and expected-value compare
// ----------------------------------------------------------------------------
module scc_crc_unit
    import scc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  scc_ctrl_t   ctrl,
    input  logic [7:0]  data_byte,
    input  logic [31:0] expected_crc,
    output logic [31:0] result_crc,
    output logic        result_match
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    assign result_crc   = ctrl.fold ? crc_fold_byte(crc_reg, data_byte) : crc_reg;
    assign result_match = (result_crc == expected_crc);
    assign crc_next     = ctrl.last ? CRC_INIT : result_crc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else if (ctrl.go)
        begin
            crc_reg <= crc_next;
        end
    end

endmodule

### rtl/sector_sampled_crc32c_check.sv
// a request is held in the input register; a block-end result is then held in the result register
// throughput: one request per cycle while in_stall is low; the byte fold and compare sit between
//   the input register and the result register
// a waiting result stalls input only when the held request also ends a block with checksum enabled
// reset: crc all ones, sector offset zero, 16 checked bytes, checksum enabled
// ----------------------------------------------------------------------------
// sector_sampled_crc32c_check
// sector-sampled crc-32c block check with expected-value compare
// ----------------------------------------------------------------------------
module sector_sampled_crc32c_check
    import scc_pkg::*;
#(
    parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 byte_valid,
    input  logic                 block_end,
    input  logic [31:0]          expected_crc,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [31:0]          crc_value,
    output logic                 crc_match
);

    logic [CFG_W-1:0] checked_reg;
    logic             enable_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_byte_valid_reg;
    logic        s1_block_end_reg;
    logic [31:0] s1_expected_reg;

    logic        out_valid_reg;
    logic [31:0] out_crc_reg;
    logic        out_match_reg;

    logic        out_free;
    logic        s1_emits;
    logic        s1_go;
    logic        in_take;
    scc_ctrl_t   ctrl;
    logic [31:0] result_crc;
    logic        result_match;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_emits = s1_block_end_reg && enable_reg;
    assign s1_go    = s1_valid_reg && (!s1_emits || out_free);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checked_reg <= CHECKED_BYTES_RESET;
            enable_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHECKED_BYTES: checked_reg <= cfg_data;
                REG_CHECKSUM_EN:   enable_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg       <= data_byte;
            s1_byte_valid_reg <= byte_valid;
            s1_block_end_reg  <= block_end;
            s1_expected_reg   <= expected_crc;
        end
    end

    scc_sampler #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_sampler (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (s1_go),
        .byte_valid    (s1_byte_valid_reg),
        .block_end     (s1_block_end_reg),
        .checked_bytes (checked_reg),
        .ctrl          (ctrl)
    );

    scc_crc_unit u_crc (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .data_byte    (s1_byte_reg),
        .expected_crc (s1_expected_reg),
        .result_crc   (result_crc),
        .result_match (result_match)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_emits)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emits)
        begin
            out_crc_reg   <= result_crc;
            out_match_reg <= result_match;
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_value = out_crc_reg;
    assign crc_match = out_match_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(s1_go && s1_emits))
        else $error("waiting result overwritten");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_emits) |=> out_valid_reg)
        else $error("block end result not presented");

    a_no_result_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_emits) |-> !in_stall)
        else $error("request without result stalled input");
`endif

endmodule
